@@ src/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ src/rau_pkg.sv @@
package rau_pkg;
    localparam int NumW = 34;
    localparam int DenW = 33;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZDEN   = 2'd1,
        ST_DIVZ   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [NumW-1:0] res_num;
        logic [DenW-1:0]        res_den;
        logic                   is_equal;
        logic [1:0]             status;
    } t_res;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] a_num;
        logic [15:0] a_den;
        logic [15:0] b_num;
        logic [15:0] b_den;
    } t_req;
endpackage

@@ src/rau_if.sv @@
interface rau_req_if;
    logic            valid;
    logic            ready;
    rau_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_res_if;
    logic            valid;
    logic            ready;
    rau_pkg::t_res   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rational_arithmetic_unit.sv @@
// sequence: products registered on accept, a prep step, a binary gcd loop, then two
// divisions (numerator, then denominator, by the gcd) and a registered output;
// errors, unknown opcodes, equality tests and zero numerators skip the gcd and divisions
// throughput: one transaction at a time, input ready again once the result is taken
// reset: synchronous active low, clears the sequencer and output valid
`include "assert_macros.svh"

module rational_arithmetic_unit #(
    parameter int PART_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_req_if.sink   i_req,
    rau_res_if.source o_res
);
    localparam int PW = PART_WIDTH;
    localparam int MW = 2 * PW + 2;
    localparam int KW = $clog2(MW + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_TWO  = 7'b0000100,
        S_ODD  = 7'b0001000,
        S_LOOP = 7'b0010000,
        S_DIVN = 7'b0100000,
        S_DIVD = 7'b1000000
    } t_state;

    t_state r_state;

    logic [PW-1:0] an_m, ad_m, bn_m, bd_m;
    logic an_s, ad_s, bn_s, bd_s;
    logic [2:0] op;

    function automatic logic [PW-1:0] magn(input logic [15:0] raw);
        logic [PW-1:0] v;
        v = PW'(raw);
        return v[PW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic sgn(input logic [15:0] raw);
        logic [PW-1:0] v;
        v = PW'(raw);
        return v[PW-1];
    endfunction

    always_comb begin
        op   = i_req.data.opcode;
        an_m = magn(i_req.data.a_num); an_s = sgn(i_req.data.a_num);
        ad_m = magn(i_req.data.a_den); ad_s = sgn(i_req.data.a_den);
        bn_m = magn(i_req.data.b_num); bn_s = sgn(i_req.data.b_num);
        bd_m = magn(i_req.data.b_den); bd_s = sgn(i_req.data.b_den);
    end

    // first stage products
    logic [2*PW-1:0] r_p0, r_p1, r_p2;
    logic r_s0, r_s1, r_s2;
    logic [2:0] r_op;
    logic [MW-1:0] r_nm, r_dm, r_x, r_y;
    logic r_neg;
    logic [KW-1:0] r_k;
    logic [MW-1:0] r_g;
    logic [MW-1:0] r_qn;
    logic div_start, div_done;
    logic [MW-1:0] div_a, div_b, div_q;
    logic [MW-1:0] sum_mag;
    logic sum_neg;
    logic [MW-1:0] ymx;

    always_comb begin
        logic [MW-1:0] a0, a1;
        a0 = MW'(r_p0);
        a1 = MW'(r_p1);
        if (r_s0 == r_s1) begin
            sum_mag = a0 + a1; sum_neg = r_s0;
        end else if (a0 >= a1) begin
            sum_mag = a0 - a1; sum_neg = r_s0;
        end else begin
            sum_mag = a1 - a0; sum_neg = r_s1;
        end
        ymx = r_y - r_x;
    end

    logic r_ovalid;
    rau_pkg::t_res r_out;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;
    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;

    logic fire;
    assign fire = i_req.valid && i_req.ready;
    assign div_a = (r_state == S_DIVN) ? r_nm : r_dm;
    assign div_b = r_g;

    rau_divider #(.W(MW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    logic r_dstart;
    assign div_start = r_dstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ovalid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (fire) begin
                        r_op <= op;
                        r_out.is_equal <= 1'b0;
                        r_out.res_num  <= '0;
                        r_out.res_den  <= rau_pkg::DenW'(1);
                        if (ad_m == '0 || bd_m == '0) begin
                            r_out.status <= rau_pkg::ST_ZDEN;
                            r_ovalid <= 1'b1;
                        end else if (op == rau_pkg::OP_DIV && bn_m == '0) begin
                            r_out.status <= rau_pkg::ST_DIVZ;
                            r_ovalid <= 1'b1;
                        end else if (op > rau_pkg::OP_EQ) begin
                            r_out.status <= rau_pkg::ST_OK;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_out.status <= rau_pkg::ST_OK;
                            r_state <= S_PREP;
                            unique case (op)
                                rau_pkg::OP_MUL: begin
                                    r_p0 <= an_m * bn_m; r_s0 <= an_s ^ bn_s;
                                    r_p2 <= ad_m * bd_m; r_s2 <= ad_s ^ bd_s;
                                end
                                rau_pkg::OP_DIV: begin
                                    r_p0 <= an_m * bd_m; r_s0 <= an_s ^ bd_s;
                                    r_p2 <= ad_m * bn_m; r_s2 <= ad_s ^ bn_s;
                                end
                                default: begin
                                    r_p0 <= an_m * bd_m; r_s0 <= an_s ^ bd_s;
                                    r_p1 <= bn_m * ad_m;
                                    r_s1 <= bn_s ^ ad_s ^ (op == rau_pkg::OP_SUB);
                                    r_p2 <= ad_m * bd_m; r_s2 <= ad_s ^ bd_s;
                                end
                            endcase
                        end
                    end
                end
                S_PREP: begin
                    logic [MW-1:0] nm;
                    logic nn;
                    if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) begin
                        nm = sum_mag; nn = sum_neg;
                    end else begin
                        nm = MW'(r_p0); nn = r_s0;
                    end
                    if (r_op == rau_pkg::OP_EQ) begin
                        r_out.is_equal <= (r_p0 == r_p1) &&
                            ((r_s0 == (r_s1 ^ 1'b0)) || r_p0 == '0);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (nm == '0) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_nm <= nm; r_dm <= MW'(r_p2);
                        r_neg <= nn ^ r_s2;
                        r_x <= nm; r_y <= MW'(r_p2);
                        r_k <= '0;
                        r_state <= S_TWO;
                    end
                end
                S_TWO: begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1; r_y <= r_y >> 1; r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_ODD;
                    end
                end
                S_ODD: begin
                    if (!r_x[0]) r_x <= r_x >> 1;
                    else r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_y == '0) begin
                        r_g <= r_x << r_k;
                        r_dstart <= 1'b1;
                        r_state <= S_DIVN;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x > r_y) begin
                        r_x <= r_y; r_y <= r_x - r_y;
                    end else begin
                        r_y <= ymx;
                    end
                end
                S_DIVN: begin
                    if (div_done) begin
                        r_qn <= div_q;
                        r_dstart <= 1'b1;
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (div_done) begin
                        r_out.res_num <= rau_pkg::NumW'(r_neg ? (~r_qn + 1'b1) : r_qn);
                        r_out.res_den <= rau_pkg::DenW'(div_q);
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, i_req.ready, r_state == S_IDLE)
    `ASSERT_IMPL(a_den_pos, i_clk, i_rst_n, r_ovalid && PW == 16, r_out.res_den != '0)
    `ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, fire, !i_req.ready)
endmodule

@@ src/rau_divider.sv @@
module rau_divider #(
    parameter int W = 66
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, n_q;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb begin
        shifted = {r_rem[W-1:0], r_q[W-1]};
        diff    = shifted - {1'b0, r_div};
        if (!diff[W]) begin
            n_rem = diff;
            n_q   = {r_q[W-2:0], 1'b1};
        end else begin
            n_rem = shifted;
            n_q   = {r_q[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_q;
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    typedef struct {
        logic signed [rau_pkg::NumW-1:0] num;
        logic [rau_pkg::DenW-1:0]        den;
        logic                            eq;
        logic [1:0]                      st;
    } t_frac_res;

    logic i_clk;
    logic i_rst_n;
    int   send_gap_pct;
    int   recv_stall_pct;
    int   errors;
    t_frac_res pending_q[$];

    rau_req_if req_bus ();
    rau_res_if res_bus ();

    rational_arithmetic_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus.sink),
        .o_res  (res_bus.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // signed products fit in 64 bits at 16-bit parts
    function automatic t_frac_res reduce(longint n, longint d, logic eq, logic [1:0] st);
        t_frac_res r;
        longint unsigned nm;
        longint unsigned dm;
        longint unsigned g;
        logic neg;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        neg = (n < 0) != (d < 0);
        if (nm == 0 || dm == 0) begin
            nm = 0;
            dm = 1;
            neg = 1'b0;
        end else begin
            g = gcd64(nm, dm);
            nm = nm / g;
            dm = dm / g;
        end
        r.num = rau_pkg::NumW'(neg ? (64'd0 - nm) : nm);
        r.den = dm[rau_pkg::DenW-1:0];
        r.eq = eq;
        r.st = st;
        return r;
    endfunction

    function automatic t_frac_res compute_fraction(rau_pkg::t_req q);
        longint an;
        longint ad;
        longint bn;
        longint bd;
        an = $signed(q.a_num);
        ad = $signed(q.a_den);
        bn = $signed(q.b_num);
        bd = $signed(q.b_den);
        if (ad == 0 || bd == 0) return reduce(0, 1, 1'b0, rau_pkg::ST_ZDEN);
        case (q.opcode)
            rau_pkg::OP_ADD: return reduce(an * bd + bn * ad, ad * bd, 1'b0, rau_pkg::ST_OK);
            rau_pkg::OP_SUB: return reduce(an * bd - bn * ad, ad * bd, 1'b0, rau_pkg::ST_OK);
            rau_pkg::OP_MUL: return reduce(an * bn, ad * bd, 1'b0, rau_pkg::ST_OK);
            rau_pkg::OP_DIV: begin
                if (bn == 0) return reduce(0, 1, 1'b0, rau_pkg::ST_DIVZ);
                return reduce(an * bd, ad * bn, 1'b0, rau_pkg::ST_OK);
            end
            rau_pkg::OP_EQ: return reduce(0, 1, an * bd == bn * ad, rau_pkg::ST_OK);
            default: return reduce(0, 1, 1'b0, rau_pkg::ST_OK);
        endcase
    endfunction

    task automatic send_fraction(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
                                 logic [15:0] bn, logic [15:0] bd);
        rau_pkg::t_req q;
        q.opcode = op;
        q.a_num = an;
        q.a_den = ad;
        q.b_num = bn;
        q.b_den = bd;
        while ($urandom_range(99) < send_gap_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data <= q;
        pending_q.push_back(compute_fraction(q));
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_part();
        case ($urandom_range(5))
            0: return 16'($urandom_range(7));
            1: return 16'(-$urandom_range(1, 8));
            2: return 16'(16'h8000 + $urandom_range(3));
            3: return 16'(16'h7fff - $urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [2:0] op;
        for (int k = 0; k <= 7; k++) begin
            op = 3'(k);
            send_fraction(op, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        end
        send_fraction(rau_pkg::OP_ADD, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001);
        send_fraction(rau_pkg::OP_SUB, 16'h0003, 16'h0004, 16'h0003, 16'h0004);
        send_fraction(rau_pkg::OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
        send_fraction(rau_pkg::OP_MUL, 16'h0001, 16'h7fff, 16'h0001, 16'h8000);
        send_fraction(rau_pkg::OP_DIV, 16'h0001, 16'h0002, 16'h0000, 16'h0005);
        send_fraction(rau_pkg::OP_DIV, 16'h0001, 16'h0000, 16'h0000, 16'h0005);
        send_fraction(rau_pkg::OP_ADD, 16'h0001, 16'h0002, 16'h0001, 16'h0000);
        send_fraction(rau_pkg::OP_EQ, 16'h0001, 16'h0002, 16'hfffe, 16'hfffc);
        send_fraction(rau_pkg::OP_EQ, 16'h0001, 16'h0002, 16'h0001, 16'h0003);
        send_fraction(rau_pkg::OP_DIV, 16'hfffd, 16'h0004, 16'h0006, 16'hfff8);
        send_fraction(rau_pkg::OP_MUL, 16'h0000, 16'hffff, 16'h0005, 16'h0003);
        send_fraction(rau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    endtask

    task automatic test_random(int count);
        logic [15:0] an;
        logic [15:0] ad;
        logic [15:0] m;
        for (int k = 0; k < count; k++) begin
            an = rand_part();
            ad = rand_part();
            if ($urandom_range(9) == 0) begin
                m = 16'($urandom_range(1, 50));
                send_fraction(rau_pkg::OP_EQ, an, ad, an * m, ad * m);
            end else begin
                send_fraction(3'($urandom_range(7)), an, ad, rand_part(), rand_part());
            end
        end
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    initial begin : result_check
        t_frac_res exp_r;
        rau_pkg::t_res got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                got = res_bus.data;
                if (pending_q.size() == 0) begin
                    $display("%0t unexpected transaction num=%0d den=%0d", $time,
                             got.res_num, got.res_den);
                    errors++;
                end else begin
                    exp_r = pending_q.pop_front();
                    if (got.res_num !== exp_r.num || got.res_den !== exp_r.den ||
                        got.is_equal !== exp_r.eq || got.status !== exp_r.st) begin
                        $display("%0t mismatch exp %0d/%0d %0b %0d got %0d/%0d %0b %0d",
                                 $time, exp_r.num, exp_r.den, exp_r.eq, exp_r.st,
                                 got.res_num, got.res_den, got.is_equal, got.status);
                        errors++;
                    end
                end
            end
            res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        errors = 0;
        send_gap_pct = 12;
        recv_stall_pct = 75;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        res_bus.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(150);
        send_gap_pct = 75;
        recv_stall_pct = 12;
        test_random(150);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(150);
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ rational_arithmetic_unit.f @@
+incdir+src
src/rau_pkg.sv
src/rau_if.sv
src/rau_divider.sv
src/rational_arithmetic_unit.sv
sim/tb_top.sv
